// ===== design/cpsc_pkg.sv =====
// Shared types and constants for the Chebyshev / power-series converter.
package cpsc_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int VAL_W      = 48;
  localparam int DEG_W      = 5;
  localparam int C_BASE     = MAX_DEGREE + 1;
  localparam int MEM_DEPTH  = 2 * MAX_DEGREE + 3;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  localparam logic REG_DEGREE    = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [DEG_W-1:0]        idx_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_MEAN = 2'd2
  } alu_op_t;

  typedef struct packed {
    idx_t degree;
    logic direction;
  } cfg_t;

  typedef struct packed {
    val_t coef;
    idx_t index;
    logic last;
    logic ovf;
  } res_t;

endpackage

// ===== design/cpsc_alu.sv =====
// Shared saturating add / subtract / mean unit.
module cpsc_alu (
  input  cpsc_pkg::alu_op_t op,
  input  cpsc_pkg::val_t    a,
  input  cpsc_pkg::val_t    b,
  output cpsc_pkg::val_t    y,
  output logic              ovf
);
  import cpsc_pkg::*;

  logic signed [VAL_W:0] s;

  always_comb begin
    case (op)
      ALU_SUB: s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      default: s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    endcase
    ovf = 1'b0;
    if (op == ALU_MEAN) begin
      y = s[VAL_W:1];
    end else if (s[VAL_W] != s[VAL_W-1]) begin
      ovf = 1'b1;
      y   = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      y = s[VAL_W-1:0];
    end
  end

endmodule

// ===== design/cpsc_engine.sv =====
// Coefficient store and conversion sequencer around the shared unit.
module cpsc_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  cpsc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  cpsc_pkg::val_t  in_coef,
  output logic            res_valid,
  input  logic            res_ready,
  output cpsc_pkg::res_t  res
);
  import cpsc_pkg::*;

  typedef enum logic [35:0] {
    ST_IDLE    = 36'b1 << 0,
    ST_T_IRD   = 36'b1 << 1,
    ST_T_IWR   = 36'b1 << 2,
    ST_T_CLR   = 36'b1 << 3,
    ST_T_A     = 36'b1 << 4,
    ST_T_B     = 36'b1 << 5,
    ST_T_C     = 36'b1 << 6,
    ST_T_D     = 36'b1 << 7,
    ST_T_E     = 36'b1 << 8,
    ST_T_F     = 36'b1 << 9,
    ST_T_G     = 36'b1 << 10,
    ST_T_H     = 36'b1 << 11,
    ST_T_I     = 36'b1 << 12,
    ST_U_RD    = 36'b1 << 13,
    ST_U_WR    = 36'b1 << 14,
    ST_U_ZERO  = 36'b1 << 15,
    ST_V_A     = 36'b1 << 16,
    ST_V_B     = 36'b1 << 17,
    ST_V_C     = 36'b1 << 18,
    ST_V_D     = 36'b1 << 19,
    ST_W_A     = 36'b1 << 20,
    ST_W_B     = 36'b1 << 21,
    ST_W_C     = 36'b1 << 22,
    ST_X_A     = 36'b1 << 23,
    ST_X_B     = 36'b1 << 24,
    ST_X_C     = 36'b1 << 25,
    ST_X_D     = 36'b1 << 26,
    ST_X_E     = 36'b1 << 27,
    ST_Y_A     = 36'b1 << 28,
    ST_Y_B     = 36'b1 << 29,
    ST_Y_C     = 36'b1 << 30,
    ST_Y_D     = 36'b1 << 31,
    ST_Y_E     = 36'b1 << 32,
    ST_Y_F     = 36'b1 << 33,
    ST_OUT_RD  = 36'b1 << 34,
    ST_OUT_WR  = 36'b1 << 35
  } state_t;

  function automatic addr_t cadr(input idx_t x);
    return addr_t'(C_BASE) + addr_t'(x);
  endfunction

  function automatic addr_t padr(input idx_t x);
    return addr_t'(x);
  endfunction

  state_t  state_r, state_nxt;
  idx_t    load_cnt_r, load_cnt_nxt;
  idx_t    n_r, n_nxt;
  logic    dir_r, dir_nxt;
  logic    sat_r, sat_nxt;
  idx_t    i_r, i_nxt;
  idx_t    j_r, j_nxt;
  val_t    cj_r, cj_nxt;
  val_t    tmp_r, tmp_nxt;
  val_t    h_r, h_nxt;
  val_t    rdata_r;
  val_t    mem_r [MEM_DEPTH];

  logic    we;
  addr_t   waddr, raddr;
  val_t    wdata;
  alu_op_t alu_op;
  val_t    alu_a, alu_b, alu_y;
  logic    alu_ovf;
  idx_t    n_eff, m_w, k0_w;

  cpsc_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y),
    .ovf (alu_ovf)
  );

  assign n_eff = (cfg.degree > idx_t'(MAX_DEGREE)) ? idx_t'(MAX_DEGREE) : cfg.degree;
  assign m_w   = idx_t'(n_r - i_r - idx_t'(2));
  assign k0_w  = idx_t'(n_r - i_r - idx_t'(3));

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_OUT_WR);
  assign res.coef  = rdata_r;
  assign res.index = j_r;
  assign res.last  = (j_r == n_r);
  assign res.ovf   = sat_r;

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    n_nxt        = n_r;
    dir_nxt      = dir_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cj_nxt       = cj_r;
    tmp_nxt      = tmp_r;
    h_nxt        = h_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    raddr        = '0;
    alu_op       = ALU_MEAN;
    alu_a        = '0;
    alu_b        = '0;
    sat_nxt      = sat_r | alu_ovf;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          we    = 1'b1;
          wdata = in_coef;
          if (load_cnt_r < n_eff) begin
            waddr        = padr(load_cnt_r);
            load_cnt_nxt = idx_t'(load_cnt_r + 1'b1);
          end else begin
            waddr        = padr(n_eff);
            load_cnt_nxt = '0;
            n_nxt        = n_eff;
            dir_nxt      = cfg.direction;
            sat_nxt      = 1'b0;
            j_nxt        = '0;
            state_nxt    = cfg.direction ? ST_U_RD : ST_T_IRD;
          end
        end
      end
      ST_T_IRD: begin
        raddr     = padr(n_r);
        state_nxt = ST_T_IWR;
      end
      ST_T_IWR: begin
        we        = 1'b1;
        waddr     = cadr('0);
        wdata     = rdata_r;
        j_nxt     = idx_t'(1);
        state_nxt = ST_T_CLR;
      end
      ST_T_CLR: begin
        we    = 1'b1;
        waddr = cadr(j_r);
        j_nxt = idx_t'(j_r + 1'b1);
        if (j_r == idx_t'(n_r + 1'b1)) begin
          i_nxt = '0;
          if (n_r == '0) begin
            j_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            state_nxt = ST_T_A;
          end
        end
      end
      ST_T_A: begin
        raddr     = cadr(idx_t'(1));
        state_nxt = ST_T_B;
      end
      ST_T_B: begin
        cj_nxt    = rdata_r;
        raddr     = cadr(idx_t'(2));
        state_nxt = ST_T_C;
      end
      ST_T_C: begin
        alu_a     = rdata_r;
        h_nxt     = alu_y;
        raddr     = cadr('0);
        state_nxt = ST_T_D;
      end
      ST_T_D: begin
        alu_op    = ALU_ADD;
        alu_a     = rdata_r;
        alu_b     = h_r;
        we        = 1'b1;
        waddr     = cadr(idx_t'(1));
        wdata     = alu_y;
        state_nxt = ST_T_E;
      end
      ST_T_E: begin
        alu_a     = cj_r;
        h_nxt     = alu_y;
        raddr     = padr(idx_t'(n_r - i_r - 1'b1));
        state_nxt = ST_T_F;
      end
      ST_T_F: begin
        alu_op = ALU_ADD;
        alu_a  = rdata_r;
        alu_b  = h_r;
        we     = 1'b1;
        waddr  = cadr('0);
        wdata  = alu_y;
        if (i_r == '0) begin
          i_nxt = idx_t'(i_r + 1'b1);
          if (idx_t'(i_r + 1'b1) == n_r) begin
            j_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            state_nxt = ST_T_A;
          end
        end else begin
          j_nxt     = idx_t'(2);
          state_nxt = ST_T_G;
        end
      end
      ST_T_G: begin
        raddr     = cadr(j_r);
        state_nxt = ST_T_H;
      end
      ST_T_H: begin
        tmp_nxt   = rdata_r;
        raddr     = cadr(idx_t'(j_r + 1'b1));
        state_nxt = ST_T_I;
      end
      ST_T_I: begin
        alu_a  = cj_r;
        alu_b  = rdata_r;
        we     = 1'b1;
        waddr  = cadr(j_r);
        wdata  = alu_y;
        cj_nxt = tmp_r;
        j_nxt  = idx_t'(j_r + 1'b1);
        if (j_r == idx_t'(i_r + 1'b1)) begin
          i_nxt = idx_t'(i_r + 1'b1);
          if (idx_t'(i_r + 1'b1) == n_r) begin
            j_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            state_nxt = ST_T_A;
          end
        end else begin
          state_nxt = ST_T_G;
        end
      end
      ST_U_RD: begin
        raddr     = padr(j_r);
        state_nxt = ST_U_WR;
      end
      ST_U_WR: begin
        we    = 1'b1;
        waddr = cadr(j_r);
        wdata = rdata_r;
        j_nxt = idx_t'(j_r + 1'b1);
        state_nxt = (j_r == n_r) ? ST_U_ZERO : ST_U_RD;
      end
      ST_U_ZERO: begin
        we    = 1'b1;
        waddr = cadr(idx_t'(n_r + 1'b1));
        i_nxt = '0;
        j_nxt = '0;
        if (n_r <= idx_t'(1)) begin
          state_nxt = ST_OUT_RD;
        end else if (n_r == idx_t'(2)) begin
          state_nxt = ST_Y_A;
        end else begin
          state_nxt = ST_V_A;
        end
      end
      ST_V_A: begin
        raddr     = cadr(m_w);
        state_nxt = ST_V_B;
      end
      ST_V_B: begin
        cj_nxt    = rdata_r;
        raddr     = cadr(idx_t'(m_w + 1'b1));
        state_nxt = ST_V_C;
      end
      ST_V_C: begin
        alu_op    = ALU_ADD;
        alu_a     = rdata_r;
        alu_b     = rdata_r;
        we        = 1'b1;
        waddr     = cadr(m_w);
        wdata     = alu_y;
        raddr     = cadr(idx_t'(m_w + idx_t'(2)));
        state_nxt = ST_V_D;
      end
      ST_V_D: begin
        alu_op    = ALU_ADD;
        alu_a     = rdata_r;
        alu_b     = rdata_r;
        we        = 1'b1;
        waddr     = cadr(idx_t'(m_w + 1'b1));
        wdata     = alu_y;
        j_nxt     = k0_w;
        state_nxt = (k0_w != '0) ? ST_W_A : ST_X_A;
      end
      ST_W_A: begin
        alu_op    = ALU_ADD;
        alu_a     = cj_r;
        alu_b     = cj_r;
        h_nxt     = alu_y;
        raddr     = cadr(idx_t'(j_r + idx_t'(2)));
        state_nxt = ST_W_B;
      end
      ST_W_B: begin
        alu_op    = ALU_SUB;
        alu_a     = h_r;
        alu_b     = rdata_r;
        tmp_nxt   = alu_y;
        raddr     = cadr(j_r);
        state_nxt = ST_W_C;
      end
      ST_W_C: begin
        cj_nxt    = rdata_r;
        we        = 1'b1;
        waddr     = cadr(j_r);
        wdata     = tmp_r;
        j_nxt     = idx_t'(j_r - 1'b1);
        state_nxt = (j_r == idx_t'(1)) ? ST_X_A : ST_W_A;
      end
      ST_X_A: begin
        raddr     = cadr(idx_t'(2));
        state_nxt = ST_X_B;
      end
      ST_X_B: begin
        alu_a     = rdata_r;
        h_nxt     = alu_y;
        raddr     = cadr('0);
        state_nxt = ST_X_C;
      end
      ST_X_C: begin
        alu_op    = ALU_SUB;
        alu_a     = cj_r;
        alu_b     = h_r;
        tmp_nxt   = rdata_r;
        we        = 1'b1;
        waddr     = cadr('0);
        wdata     = alu_y;
        raddr     = cadr(idx_t'(1));
        state_nxt = ST_X_D;
      end
      ST_X_D: begin
        alu_a     = rdata_r;
        h_nxt     = alu_y;
        state_nxt = ST_X_E;
      end
      ST_X_E: begin
        alu_op    = ALU_SUB;
        alu_a     = tmp_r;
        alu_b     = h_r;
        we        = 1'b1;
        waddr     = padr(i_r);
        wdata     = alu_y;
        i_nxt     = idx_t'(i_r + 1'b1);
        state_nxt = (idx_t'(i_r + idx_t'(3)) < n_r) ? ST_V_A : ST_Y_A;
      end
      ST_Y_A: begin
        raddr     = cadr('0);
        state_nxt = ST_Y_B;
      end
      ST_Y_B: begin
        cj_nxt    = rdata_r;
        raddr     = cadr(idx_t'(1));
        state_nxt = ST_Y_C;
      end
      ST_Y_C: begin
        we        = 1'b1;
        waddr     = padr(idx_t'(n_r - 1'b1));
        wdata     = rdata_r;
        raddr     = cadr(idx_t'(2));
        state_nxt = ST_Y_D;
      end
      ST_Y_D: begin
        alu_op    = ALU_ADD;
        alu_a     = rdata_r;
        alu_b     = rdata_r;
        h_nxt     = alu_y;
        state_nxt = ST_Y_E;
      end
      ST_Y_E: begin
        alu_a     = h_r;
        tmp_nxt   = alu_y;
        we        = 1'b1;
        waddr     = padr(n_r);
        wdata     = h_r;
        state_nxt = ST_Y_F;
      end
      ST_Y_F: begin
        alu_op    = ALU_SUB;
        alu_a     = cj_r;
        alu_b     = tmp_r;
        we        = 1'b1;
        waddr     = padr(idx_t'(n_r - idx_t'(2)));
        wdata     = alu_y;
        j_nxt     = '0;
        state_nxt = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        raddr     = dir_r ? padr(j_r) : cadr(j_r);
        state_nxt = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        raddr = dir_r ? padr(j_r) : cadr(j_r);
        if (res_ready) begin
          j_nxt     = idx_t'(j_r + 1'b1);
          state_nxt = (j_r == n_r) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      sat_r      <= 1'b0;
      n_r        <= '0;
      dir_r      <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      sat_r      <= sat_nxt;
      n_r        <= n_nxt;
      dir_r      <= dir_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cj_r  <= cj_nxt;
    tmp_r <= tmp_nxt;
    h_r   <= h_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// ===== design/chebyshev_power_series_convert_core.sv =====
// Top level: config registers, sequencer and output word register.
// Load: one word per cycle while in_stall is low; degree+1 words, the last starts the conversion.
// Conversion: one shared add/sub unit and one coefficient memory port pair do the work;
//   emission reads each word from the store and holds it until taken before the next read.
// Input is stalled from the last load word until the last result word is taken into the output register.
// Reset (rst_n low, synchronous) clears control and config; the store is undefined.
module chebyshev_power_series_convert_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [47:0]    in_coef_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [47:0]    out_coef_out,
  output logic [4:0]            out_coef_index,
  output logic                  out_last,
  output logic                  out_overflow
);
  import cpsc_pkg::*;

  cfg_t cfg_r;
  logic res_valid, res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGREE:    cfg_r.degree    <= cfg_data[DEG_W-1:0];
        REG_DIRECTION: cfg_r.direction <= cfg_data[0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  cpsc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coef   (in_coef_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coef_out   = out_r.coef;
  assign out_coef_index = out_r.index;
  assign out_last       = out_r.last;
  assign out_overflow   = out_r.ovf;

endmodule

// ===== design/cpsc_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module cpsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [47:0] out_coef_out,
  input logic [4:0]        out_coef_index,
  input logic              out_last
);
  import cpsc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coef_out) && $stable(out_coef_index))
    else $error("stalled output word changed");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coef_index <= 5'(MAX_DEGREE))
    else $error("output index beyond max degree");

  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken while a conversion is still emitting");

endmodule

bind chebyshev_power_series_convert_core cpsc_checker u_cpsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coef_out   (out_coef_out),
  .out_coef_index (out_coef_index),
  .out_last       (out_last)
);
